// File: hdl/pit_pkg.sv
// ----------------------------------------------------------------------------
// pit_pkg
// Shared types and constants of the periodic interval timer.
// ----------------------------------------------------------------------------
package pit_pkg;

   localparam int LIMIT_W = 20;
   localparam int OVF_W   = 12;
   localparam int WORD_W  = 32;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [1:0] REG_MODE   = 2'd0;
   localparam logic [1:0] REG_STATUS = 2'd1;
   localparam logic [1:0] REG_VALUE  = 2'd2;
   localparam logic [1:0] REG_IMAGE  = 2'd3;

   localparam int EN_BIT  = 24;
   localparam int IEN_BIT = 25;

   typedef struct packed {
      logic [1:0]        op;
      logic [1:0]        reg_index;
      logic              word_access;
      logic [WORD_W-1:0] write_data;
   } pit_req_type;

   typedef struct packed {
      logic [WORD_W-1:0] read_data;
      logic              bus_error;
      logic              irq;
   } pit_rsp_type;

   typedef struct packed {
      logic               counting;
      logic               timer_enable;
      logic               interrupt_enable;
      logic               reached;
      logic [LIMIT_W-1:0] counter;
   } pit_status_type;

endpackage

// File: hdl/pit_prescale.sv
// ----------------------------------------------------------------------------
// pit_prescale
// Free-running clock-tick divider; pulses wrap on every PRESCALE-th tick.
// ----------------------------------------------------------------------------
module pit_prescale #(
   parameter int PRESCALE = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic tick,
   output logic wrap
);

   localparam int CNT_W = (PRESCALE > 1) ? $clog2(PRESCALE) : 1;
   localparam logic [CNT_W-1:0] LAST = CNT_W'(PRESCALE - 1);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign wrap = tick && (count_ff == LAST);

   always_comb begin
      count_in = count_ff;
      if (tick) begin
         count_in = wrap ? '0 : count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// File: hdl/pit_core.sv
// ----------------------------------------------------------------------------
// pit_core
// Mode, status and interval counter registers; executes one item per cycle of item_go.
// ----------------------------------------------------------------------------
module pit_core
   import pit_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           item_go,
   input  pit_req_type    item,
   input  logic           prescale_wrap,
   output logic           tick_go,
   output pit_rsp_type    rsp,
   output pit_status_type status
);

   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               en_ff, en_in;
   logic               ien_ff, ien_in;
   logic [LIMIT_W-1:0] counter_ff, counter_in;
   logic [OVF_W-1:0]   ovf_ff, ovf_in;
   logic               reached_ff, reached_in;
   logic               counting_ff, counting_in;
   logic [WORD_W-1:0]  value_word;

   assign tick_go    = item_go && (item.op == OP_TICK);
   assign value_word = {ovf_ff, counter_ff};

   always_comb begin
      limit_in    = limit_ff;
      en_in       = en_ff;
      ien_in      = ien_ff;
      counter_in  = counter_ff;
      ovf_in      = ovf_ff;
      reached_in  = reached_ff;
      counting_in = counting_ff;
      rsp.read_data = '0;
      rsp.bus_error = 1'b0;
      if (item_go) begin
         case (item.op)
            OP_TICK: begin
               if (prescale_wrap && counting_ff) begin
                  if (counter_ff == limit_ff) begin
                     counter_in = '0;
                     ovf_in     = ovf_ff + OVF_W'(1);
                     reached_in = 1'b1;
                     if (!en_ff) begin
                        counting_in = 1'b0;
                     end
                  end else begin
                     counter_in = counter_ff + LIMIT_W'(1);
                  end
               end
            end
            OP_WRITE: begin
               if (item.word_access && item.reg_index == REG_MODE) begin
                  limit_in = item.write_data[LIMIT_W-1:0];
                  en_in    = item.write_data[EN_BIT];
                  ien_in   = item.write_data[IEN_BIT];
                  if (item.write_data[EN_BIT]) begin
                     counting_in = 1'b1;
                  end
               end else begin
                  rsp.bus_error = 1'b1;
               end
            end
            OP_READ: begin
               if (!item.word_access) begin
                  rsp.bus_error = 1'b1;
               end else begin
                  case (item.reg_index)
                     REG_MODE: begin
                        rsp.read_data = WORD_W'(limit_ff);
                        rsp.read_data[EN_BIT]  = en_ff;
                        rsp.read_data[IEN_BIT] = ien_ff;
                     end
                     REG_STATUS: rsp.read_data = WORD_W'(reached_ff);
                     REG_VALUE: begin
                        rsp.read_data = value_word;
                        reached_in    = 1'b0;
                        ovf_in        = '0;
                     end
                     REG_IMAGE: rsp.read_data = value_word;
                     default:   rsp.read_data = '0;
                  endcase
               end
            end
            default: begin
            end
         endcase
      end
      rsp.irq = reached_in && ien_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= '1;
         en_ff       <= 1'b0;
         ien_ff      <= 1'b0;
         counter_ff  <= '0;
         ovf_ff      <= '0;
         reached_ff  <= 1'b0;
         counting_ff <= 1'b0;
      end else begin
         limit_ff    <= limit_in;
         en_ff       <= en_in;
         ien_ff      <= ien_in;
         counter_ff  <= counter_in;
         ovf_ff      <= ovf_in;
         reached_ff  <= reached_in;
         counting_ff <= counting_in;
      end
   end

   assign status.counting         = counting_ff;
   assign status.timer_enable     = en_ff;
   assign status.interrupt_enable = ien_ff;
   assign status.reached          = reached_ff;
   assign status.counter          = counter_ff;

endmodule

// File: hdl/periodic_interval_timer_top.sv
// ----------------------------------------------------------------------------
// periodic_interval_timer_top
// Periodic interval timer with prescaler, 20-bit counter and overflow count.
// ----------------------------------------------------------------------------
// Each item is a clock tick, a register write or a register read; every item
// returns one result item. An item is captured in an input register, executed
// against the timer registers once the result register is free and lands in
// the result register, so one item is taken per cycle unless the input stalls;
// the result register stalls the input side only while a result is held back.
module periodic_interval_timer_top
   import pit_pkg::*;
#(
   parameter int PRESCALE = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  pit_req_type req_item,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output pit_rsp_type rsp_item
);

   logic           in_valid_ff, in_valid_in;
   pit_req_type    in_item_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   pit_rsp_type    rsp_item_ff;
   pit_rsp_type    core_rsp;
   pit_status_type status;
   logic           out_free;
   logic           advance;
   logic           req_take;
   logic           tick_go;
   logic           prescale_wrap;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !out_free);

   pit_prescale #(
      .PRESCALE(PRESCALE)
   ) u_prescale (
      .clock(clock),
      .reset(reset),
      .tick (tick_go),
      .wrap (prescale_wrap)
   );

   pit_core u_core (
      .clock        (clock),
      .reset        (reset),
      .item_go      (advance),
      .item         (in_item_ff),
      .prescale_wrap(prescale_wrap),
      .tick_go      (tick_go),
      .rsp          (core_rsp),
      .status       (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         rsp_item_ff <= core_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_counter_idle: assert property (@(posedge clock) disable iff (reset)
      status.counter != '0 |-> status.counting)
      else $error("interval counter moved while not counting");

   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !rsp_stall |=> rsp_valid_ff)
      else $error("captured item did not reach result register");

   a_error_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.bus_error |-> rsp_item_ff.read_data == '0)
      else $error("bus error result carries read data");

   a_irq_enabled: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_item_ff.irq == (status.reached && status.interrupt_enable))
      else $error("irq level does not match status and enable");

endmodule

// File: verif/periodic_interval_timer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_interval_timer_top_tb
// Self-checking bench for the periodic interval timer. A driver offers
// ticks, register writes and register reads from a queue. The monitor keeps
// its own copy of the timer state, predicts one result per accepted item and
// compares each result field by field. Sender and receiver idle at random,
// and one long receiver hold-off fills the pipeline and stalls the input.
// ----------------------------------------------------------------------------
module periodic_interval_timer_top_tb
   import pit_pkg::*;
;

   localparam int         PRESCALE_DIV   = 16;
   localparam int         WATCHDOG_LIMIT = 3000;
   localparam int         HOLDOFF_CYCLES = 300;
   localparam int         HOLDOFF_AT     = 400;
   localparam int         RANDOM_ITEMS   = 1520;
   localparam int         DRAIN_CYCLES   = 20;
   localparam logic [1:0] OP_UNUSED      = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   pit_req_type req_item = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   pit_rsp_type rsp_item;

   pit_req_type pending_items[$];
   pit_rsp_type expected_rsps[$];

   int error_count   = 0;
   int total_items   = 0;
   int issued_count  = 0;
   int rsp_count     = 0;
   int holdoff_left  = 0;
   bit holdoff_done  = 1'b0;
   int quiet_cycles  = 0;
   int tx_idle_pct;
   int rx_idle_pct;

   // timer state as seen from the bus
   logic [LIMIT_W-1:0] t_limit;
   logic               t_enable;
   logic               t_irq_en;
   logic [LIMIT_W-1:0] t_counter;
   logic [OVF_W-1:0]   t_overflow;
   logic               t_reached;
   logic               t_counting;
   logic [3:0]         t_prescale;

   periodic_interval_timer_top #(.PRESCALE(PRESCALE_DIV)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic pit_req_type mk_item(logic [1:0] op, logic [1:0] reg_index,
                                           logic word_access, logic [WORD_W-1:0] data);
      pit_req_type it;
      it.op          = op;
      it.reg_index   = reg_index;
      it.word_access = word_access;
      it.write_data  = data;
      return it;
   endfunction

   task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                  logic [WORD_W-1:0] want);
      $display("mismatch at result %0d: %s got %h expected %h", rsp_count, what, got, want);
      error_count++;
   endtask

   task automatic predict_rsp(input pit_req_type it, output pit_rsp_type r);
      r = '0;
      case (it.op)
         OP_TICK: begin
            if (int'(t_prescale) + 1 >= PRESCALE_DIV) begin
               t_prescale = '0;
               if (t_counting) begin
                  if (t_counter == t_limit) begin
                     t_counter  = '0;
                     t_overflow = t_overflow + 1'b1;
                     t_reached  = 1'b1;
                     if (!t_enable)
                        t_counting = 1'b0;
                  end else begin
                     t_counter = t_counter + 1'b1;
                  end
               end
            end else begin
               t_prescale = t_prescale + 1'b1;
            end
         end
         OP_WRITE: begin
            if (it.word_access && it.reg_index == REG_MODE) begin
               t_limit  = it.write_data[LIMIT_W-1:0];
               t_enable = it.write_data[EN_BIT];
               t_irq_en = it.write_data[IEN_BIT];
               if (t_enable)
                  t_counting = 1'b1;
            end else begin
               r.bus_error = 1'b1;
            end
         end
         OP_READ: begin
            if (!it.word_access) begin
               r.bus_error = 1'b1;
            end else begin
               case (it.reg_index)
                  REG_MODE: begin
                     r.read_data[LIMIT_W-1:0] = t_limit;
                     r.read_data[EN_BIT]      = t_enable;
                     r.read_data[IEN_BIT]     = t_irq_en;
                  end
                  REG_STATUS: r.read_data[0] = t_reached;
                  REG_VALUE: begin
                     r.read_data = {t_overflow, t_counter};
                     t_reached   = 1'b0;
                     t_overflow  = '0;
                  end
                  default: r.read_data = {t_overflow, t_counter};
               endcase
            end
         end
         default: ;
      endcase
      r.irq = t_reached & t_irq_en;
   endtask

   // sender: offer the next item unless idling, hold it while stalled
   always @(posedge clock) begin
      if (issued_count < total_items / 3)
         tx_idle_pct = 35;
      else if (issued_count < 2 * total_items / 3)
         tx_idle_pct = 51;
      else
         tx_idle_pct = 0;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_items.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
            req_item  <= pending_items.pop_front();
            req_valid <= 1'b1;
            issued_count++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls by phase, plus one long hold-off
   always @(posedge clock) begin
      if (rsp_count < total_items / 3)
         rx_idle_pct = 51;
      else if (rsp_count < 2 * total_items / 3)
         rx_idle_pct = 35;
      else
         rx_idle_pct = 0;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (holdoff_left > 0) begin
         rsp_stall    <= 1'b1;
         holdoff_left <= holdoff_left - 1;
      end else if (!holdoff_done && rsp_count >= HOLDOFF_AT) begin
         rsp_stall    <= 1'b1;
         holdoff_left <= HOLDOFF_CYCLES;
         holdoff_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
   end

   // monitor: check results, then predict for the item taken at this edge
   always @(posedge clock) begin
      pit_rsp_type want;
      pit_rsp_type predicted;
      if (reset) begin
         t_limit    = '1;
         t_enable   = 1'b0;
         t_irq_en   = 1'b0;
         t_counter  = '0;
         t_overflow = '0;
         t_reached  = 1'b0;
         t_counting = 1'b0;
         t_prescale = '0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected result, read_data", rsp_item.read_data, '0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_item.read_data !== want.read_data)
                  report_mismatch("read_data", rsp_item.read_data, want.read_data);
               if (rsp_item.bus_error !== want.bus_error)
                  report_mismatch("bus_error", 32'(rsp_item.bus_error), 32'(want.bus_error));
               if (rsp_item.irq !== want.irq)
                  report_mismatch("irq", 32'(rsp_item.irq), 32'(want.irq));
            end
            rsp_count++;
         end
         if (req_valid && !req_stall) begin
            predict_rsp(req_item, predicted);
            expected_rsps.push_back(predicted);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("periodic_interval_timer_top_tb: done, errors");
         $finish;
      end
   end

   initial begin
      int               body_len;
      int               pick;
      logic [WORD_W-1:0] data;

      // registers right after reset
      pending_items.push_back(mk_item(OP_READ, REG_MODE, 1'b1, '0));
      pending_items.push_back(mk_item(OP_READ, REG_STATUS, 1'b1, '0));
      pending_items.push_back(mk_item(OP_READ, REG_VALUE, 1'b1, '0));
      pending_items.push_back(mk_item(OP_READ, REG_IMAGE, 1'b1, '0));
      // non-word accesses, writes to read-only registers, unused op
      pending_items.push_back(mk_item(OP_READ, REG_MODE, 1'b0, '0));
      pending_items.push_back(mk_item(OP_WRITE, REG_MODE, 1'b0, '1));
      pending_items.push_back(mk_item(OP_WRITE, REG_STATUS, 1'b1, '1));
      pending_items.push_back(mk_item(OP_WRITE, REG_VALUE, 1'b1, '1));
      pending_items.push_back(mk_item(OP_WRITE, REG_IMAGE, 1'b1, '1));
      pending_items.push_back(mk_item(OP_UNUSED, REG_IMAGE, 1'b1, '1));
      // undefined mode bits drop
      pending_items.push_back(mk_item(OP_WRITE, REG_MODE, 1'b1, '1));
      pending_items.push_back(mk_item(OP_READ, REG_MODE, 1'b1, '0));
      // limit 0: every prescaled tick wraps
      pending_items.push_back(mk_item(OP_WRITE, REG_MODE, 1'b1, 32'h0300_0000));
      repeat (16) pending_items.push_back(mk_item(OP_TICK, REG_MODE, 1'b1, '0));
      pending_items.push_back(mk_item(OP_READ, REG_STATUS, 1'b1, '0));
      pending_items.push_back(mk_item(OP_READ, REG_IMAGE, 1'b1, '0));
      pending_items.push_back(mk_item(OP_READ, REG_VALUE, 1'b1, '0));
      pending_items.push_back(mk_item(OP_READ, REG_STATUS, 1'b1, '0));
      // disable: run to the limit, then stop
      pending_items.push_back(mk_item(OP_WRITE, REG_MODE, 1'b1, 32'h0200_0000));
      pending_items.push_back(mk_item(OP_WRITE, REG_MODE, 1'b1, 32'h0000_0000));

      while (pending_items.size() < RANDOM_ITEMS) begin
         data = $urandom;
         if ($urandom_range(0, 99) < 85) begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
               data[LIMIT_W-1:0] = LIMIT_W'($urandom_range(0, 5));
            else if (pick < 90)
               data[LIMIT_W-1:0] = '1;
            data[EN_BIT]  = ($urandom_range(0, 99) < 75);
            data[IEN_BIT] = ($urandom_range(0, 99) < 60);
            pending_items.push_back(mk_item(OP_WRITE, REG_MODE, 1'b1, data));
         end else begin
            pending_items.push_back(mk_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                                            1'($urandom_range(0, 1)), data));
         end
         body_len = $urandom_range(20, 80);
         repeat (body_len) begin
            pick = $urandom_range(0, 99);
            data = $urandom;
            if (pick < 65)
               pending_items.push_back(mk_item(OP_TICK, 2'($urandom_range(0, 3)),
                                               1'($urandom_range(0, 1)), data));
            else if (pick < 85)
               pending_items.push_back(mk_item(OP_READ, 2'($urandom_range(0, 3)),
                                               ($urandom_range(0, 99) < 92), data));
            else if (pick < 90)
               pending_items.push_back(mk_item(OP_WRITE, 2'($urandom_range(0, 3)),
                                               1'($urandom_range(0, 1)), data));
            else if (pick < 95)
               pending_items.push_back(mk_item(OP_UNUSED, 2'($urandom_range(0, 3)),
                                               1'($urandom_range(0, 1)), data));
            else
               pending_items.push_back(mk_item(OP_READ, 2'($urandom_range(0, 3)), 1'b0, data));
         end
      end
      total_items = pending_items.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("periodic_interval_timer_top_tb: done, clean");
      else
         $display("periodic_interval_timer_top_tb: done, errors");
      $finish;
   end

endmodule
